// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the crc block top-level rtl
// assumes the asserting module has signals named clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define CCRC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("ccrc assertion failed");

// antecedent this cycle implies consequent next cycle
`define CCRC_ASSERT_NEXT(label, ante, cons) \
   `CCRC_ASSERT(label, (ante) |=> (cons))

`endif

// ===== hw/rtl/ccrc_pkg.sv =====
// shared constants, types and register codes for the configurable crc block
// no dependencies
package ccrc_pkg;

   localparam int MAX_DEGREE  = 32;
   localparam int MIN_DEGREE  = 8;
   localparam int CRC_W       = MAX_DEGREE;
   localparam int BYTE_W      = 8;
   localparam int DEGREE_W    = 6;
   localparam int SHIFT_W     = $clog2(MAX_DEGREE - MIN_DEGREE + 1);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [DEGREE_W-1:0] DEGREE_RESET = DEGREE_W'(16);
   localparam logic [CRC_W-1:0]    POLY_RESET   = CRC_W'(32'h0000_1021);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEGREE = 2'd0,
      CSR_POLY   = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] align_shift;
      logic [CRC_W-1:0]   poly;
   } crc_cfg_type;

endpackage

// ===== hw/rtl/ccrc_if.sv =====
// valid/ready channel interfaces for the crc block: request, response, csr write
// depends on ccrc_pkg
interface ccrc_req_if import ccrc_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;
   logic [CRC_W-1:0]  received_crc;

   modport source (output valid, data_byte, last_byte, received_crc, input ready);
   modport sink   (input valid, data_byte, last_byte, received_crc, output ready);
endinterface

interface ccrc_rsp_if import ccrc_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [CRC_W-1:0] crc_value;
   logic             crc_matches;

   modport source (output valid, crc_value, crc_matches, input ready);
   modport sink   (input valid, crc_value, crc_matches, output ready);
endinterface

interface ccrc_csr_if import ccrc_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] wr_index;
   logic [CSR_DATA_W-1:0]  wr_data;

   modport source (output valid, wr_index, wr_data, input ready);
   modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

// ===== hw/rtl/ccrc_csr.sv =====
// configuration registers for the crc block, degree clamping and alignment shift
// depends on ccrc_pkg and ccrc_csr_if
module ccrc_csr import ccrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ccrc_csr_if.sink    csr_chan,
   output crc_cfg_type cfg
);

   logic [DEGREE_W-1:0] degree_ff, degree_in;
   logic [CRC_W-1:0]    poly_ff, poly_in;
   logic [DEGREE_W-1:0] eff_degree;
   logic [DEGREE_W-1:0] shift_full;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      degree_in = degree_ff;
      poly_in   = poly_ff;
      if (csr_chan.valid) begin
         case (csr_chan.wr_index)
            CSR_DEGREE: degree_in = csr_chan.wr_data[DEGREE_W-1:0];
            CSR_POLY:   poly_in   = csr_chan.wr_data[CRC_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEGREE_RESET;
         poly_ff   <= POLY_RESET;
      end else begin
         degree_ff <= degree_in;
         poly_ff   <= poly_in;
      end
   end

   always_comb begin
      if (degree_ff < DEGREE_W'(MIN_DEGREE)) begin
         eff_degree = DEGREE_W'(MIN_DEGREE);
      end else if (degree_ff > DEGREE_W'(MAX_DEGREE)) begin
         eff_degree = DEGREE_W'(MAX_DEGREE);
      end else begin
         eff_degree = degree_ff;
      end
      shift_full = DEGREE_W'(CRC_W) - eff_degree;
   end

   assign cfg.align_shift = shift_full[SHIFT_W-1:0];
   assign cfg.poly        = poly_ff;

endmodule

// ===== hw/rtl/ccrc_byte_step.sv =====
// one byte of msb-first crc division, done on a top-aligned copy of the remainder
// depends on ccrc_pkg
module ccrc_byte_step import ccrc_pkg::*; (
   input  crc_cfg_type       cfg,
   input  logic [CRC_W-1:0]  rem_cur,
   input  logic [BYTE_W-1:0] data_byte,
   output logic [CRC_W-1:0]  rem_next
);

   logic [CRC_W-1:0] poly_al;
   logic [CRC_W-1:0] work;

   always_comb begin
      poly_al = cfg.poly << cfg.align_shift;
      work    = (rem_cur << cfg.align_shift) ^ {data_byte, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         if (work[CRC_W-1]) begin
            work = (work << 1) ^ poly_al;
         end else begin
            work = work << 1;
         end
      end
      rem_next = work >> cfg.align_shift;
   end

endmodule

// ===== hw/rtl/configurable_crc_generate_check.sv =====
// channel   dir  payload                                  handshake
// req_chan  in   data_byte, last_byte, received_crc       valid/ready
// rsp_chan  out  crc_value, crc_matches                   valid/ready
// csr_chan  in   wr_index, wr_data (degree, polynomial)   valid/ready, always ready
// one byte per cycle sustained unless a last byte waits on a stalled response;
// each byte sits in an input register, then the eight-step xor-shift chain updates the
// remainder register from it; a result goes through the output register onto rsp_chan
// reset clears the remainder and both valid flags and restores degree 16, poly 0x1021
// a stalled response holds only a waiting last byte; other bytes keep flowing
// depends on ccrc_pkg, ccrc_if, ccrc_csr, ccrc_byte_step, assert_macros.svh
`include "assert_macros.svh"

module configurable_crc_generate_check import ccrc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ccrc_req_if.sink   req_chan,
   ccrc_rsp_if.source rsp_chan,
   ccrc_csr_if.sink   csr_chan
);

   crc_cfg_type cfg;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_last_ff, in_last_in;
   logic [CRC_W-1:0]  in_rx_ff, in_rx_in;
   logic [CRC_W-1:0]  rem_ff, rem_in;
   logic              out_valid_ff, out_valid_in;
   logic [CRC_W-1:0]  out_crc_ff, out_crc_in;
   logic              out_match_ff, out_match_in;

   logic [CRC_W-1:0]  rem_next;
   logic              fire;
   logic              req_take;

   ccrc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ccrc_byte_step u_step (
      .cfg       (cfg),
      .rem_cur   (rem_ff),
      .data_byte (in_byte_ff),
      .rem_next  (rem_next)
   );

   assign fire           = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      in_rx_in     = in_rx_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff;
      out_crc_in   = out_crc_ff;
      out_match_in = out_match_ff;

      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (fire) begin
         in_valid_in = 1'b0;
         if (in_last_ff) begin
            rem_in       = '0;
            out_valid_in = 1'b1;
            out_crc_in   = rem_next;
            out_match_in = (rem_next == in_rx_ff);
         end else begin
            rem_in = rem_next;
         end
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.data_byte;
         in_last_in  = req_chan.last_byte;
         in_rx_in    = req_chan.received_crc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      in_last_ff   <= in_last_in;
      in_rx_ff     <= in_rx_in;
      out_crc_ff   <= out_crc_in;
      out_match_ff <= out_match_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.crc_value   = out_crc_ff;
   assign rsp_chan.crc_matches = out_match_ff;

   // remainder restarts from zero after each message
   `CCRC_ASSERT_NEXT(a_rem_clear, fire && in_last_ff, rem_ff == '0)
   // a finished message always produces a response
   `CCRC_ASSERT_NEXT(a_rsp_loaded, fire && in_last_ff, out_valid_ff)
   // a blocked last byte stays in the input register
   `CCRC_ASSERT_NEXT(a_last_held, in_valid_ff && in_last_ff && out_valid_ff && !rsp_chan.ready,
                     in_valid_ff && in_last_ff)
   // backpressure only comes from an occupied input register
   `CCRC_ASSERT(a_ready_cause, !req_chan.ready |-> in_valid_ff && in_last_ff && out_valid_ff)
   // a middle byte never raises a response when none is waiting
   `CCRC_ASSERT_NEXT(a_mid_no_rsp, fire && !in_last_ff && !out_valid_ff, !out_valid_ff)

endmodule

// ===== dv/ccrc_checker.sv =====
// result checker for the configurable crc block: follows csr writes, predicts the crc
// of every message from the accepted request transactions and compares each response
// depends on ccrc_pkg and the channel interfaces in ccrc_if
module ccrc_checker import ccrc_pkg::*; (
   input  logic clock,
   input  logic reset,
   ccrc_req_if  req_chan,
   ccrc_rsp_if  rsp_chan,
   ccrc_csr_if  csr_chan,
   output int   error_count,
   output int   results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CRC_W-1:0] crc_value;
      logic             crc_matches;
   } crc_result_type;

   logic [DEGREE_W-1:0] degree_reg;
   logic [CRC_W-1:0]    poly_reg;
   logic [CRC_W-1:0]    running_crc;
   crc_result_type      expected_crcs[$];
   int                  errors = 0;

   function automatic int unsigned clamp_degree(logic [DEGREE_W-1:0] field);
      if (field < MIN_DEGREE) return MIN_DEGREE;
      if (field > MAX_DEGREE) return MAX_DEGREE;
      return 32'(field);
   endfunction

   function automatic logic [CRC_W-1:0] degree_mask(int unsigned deg);
      if (deg >= CRC_W) return {CRC_W{1'b1}};
      return (CRC_W'(1) << deg) - CRC_W'(1);
   endfunction

   // one message byte through the msb-first xor-shift, masked to the degree
   function automatic logic [CRC_W-1:0] crc_byte_step(logic [CRC_W-1:0] crc_in,
         logic [BYTE_W-1:0] data, logic [DEGREE_W-1:0] degree_field,
         logic [CRC_W-1:0] poly);
      int unsigned      deg;
      logic [CRC_W-1:0] mask;
      logic [CRC_W-1:0] crc;
      deg  = clamp_degree(degree_field);
      mask = degree_mask(deg);
      crc  = (crc_in & mask) ^ (CRC_W'(data) << (deg - BYTE_W));
      for (int k = 0; k < BYTE_W; k++) begin
         if (crc[deg-1]) begin
            crc = ((crc << 1) ^ (poly & mask)) & mask;
         end else begin
            crc = (crc << 1) & mask;
         end
      end
      return crc;
   endfunction

   always @(posedge clock) begin : predict_and_compare
      crc_result_type   got;
      crc_result_type   want;
      logic [CRC_W-1:0] next_crc;
      if (reset) begin
         degree_reg  = DEGREE_RESET;
         poly_reg    = POLY_RESET;
         running_crc = '0;
         expected_crcs.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{crc_value: rsp_chan.crc_value, crc_matches: rsp_chan.crc_matches};
            if (expected_crcs.size() == 0) begin
               errors++;
               $display("%0t: unexpected response: expected none, actual crc %h match %b",
                        $time, got.crc_value, got.crc_matches);
            end else begin
               want = expected_crcs.pop_front();
               if (got.crc_value !== want.crc_value) begin
                  errors++;
                  $display("%0t: crc_value mismatch: expected %h actual %h",
                           $time, want.crc_value, got.crc_value);
               end
               if (got.crc_matches !== want.crc_matches) begin
                  errors++;
                  $display("%0t: crc_matches mismatch: expected %b actual %b",
                           $time, want.crc_matches, got.crc_matches);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            next_crc = crc_byte_step(running_crc, req_chan.data_byte, degree_reg, poly_reg);
            if (req_chan.last_byte) begin
               expected_crcs.push_back('{crc_value: next_crc,
                                         crc_matches: next_crc == req_chan.received_crc});
               running_crc = '0;
            end else begin
               running_crc = next_crc;
            end
         end
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_index_type'(csr_chan.wr_index))
               CSR_DEGREE: degree_reg = csr_chan.wr_data[DEGREE_W-1:0];
               CSR_POLY:   poly_reg   = csr_chan.wr_data;
               default: ;
            endcase
         end
      end
      error_count     <= errors;
      results_pending <= expected_crcs.size();
   end

endmodule

// ===== dv/configurable_crc_generate_check_tb.sv =====
// testbench top for the configurable crc block: clock, reset, message stimulus with
// bursts and gaps, response stalls, csr phases, watchdog and the final verdict
// depends on ccrc_pkg, ccrc_if, ccrc_checker and the block itself
module configurable_crc_generate_check_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ccrc_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int RANDOM_ITEMS   = 1330;
   localparam int NUM_PHASES     = 14;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum {RX_MATCH, RX_ABOVE_DEGREE, RX_RANDOM, RX_GIVEN} rx_choice_type;
   typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_style_type;

   logic                clock;
   logic                reset;
   int                  error_count;
   int                  results_pending;
   logic [DEGREE_W-1:0] degree_now;
   logic [CRC_W-1:0]    poly_now;
   int                  burst_left;
   int                  bytes_sent;

   ccrc_req_if req_if ();
   ccrc_rsp_if rsp_if ();
   ccrc_csr_if csr_if ();

   configurable_crc_generate_check DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   ccrc_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_if),
      .rsp_chan        (rsp_if),
      .csr_chan        (csr_if),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #(HALF_PERIOD) clock = ~clock;
   end

   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last,
                            input logic [CRC_W-1:0] rx);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_if.valid        <= 1'b1;
      req_if.data_byte    <= data;
      req_if.last_byte    <= last;
      req_if.received_crc <= rx;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   // hold the sender until every crc result is back, then let the pipeline settle
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_if.valid    <= 1'b1;
      csr_if.wr_index <= index;
      csr_if.wr_data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (index == CSR_DEGREE) degree_now = data[DEGREE_W-1:0];
      else if (index == CSR_POLY) poly_now = data;
      @(posedge clock);
   endtask

   task automatic send_message(input logic [BYTE_W-1:0] msg[$], input rx_choice_type choice,
                               input logic [CRC_W-1:0] given);
      logic [CRC_W-1:0] crc;
      logic [CRC_W-1:0] rx;
      int unsigned      deg;
      crc = '0;
      deg = u_checker.clamp_degree(degree_now);
      foreach (msg[i]) begin
         crc = u_checker.crc_byte_step(crc, msg[i], degree_now, poly_now);
         if (i < msg.size() - 1) begin
            send_byte(msg[i], 1'b0, $urandom());
         end else begin
            case (choice)
               RX_MATCH:        rx = crc;
               RX_ABOVE_DEGREE: rx = (deg < CRC_W) ? crc | (CRC_W'(1) << $urandom_range(deg, 31))
                                                   : crc ^ (CRC_W'(1) << $urandom_range(0, 31));
               RX_RANDOM:       rx = $urandom();
               default:         rx = given;
            endcase
            send_byte(msg[i], 1'b1, rx);
         end
      end
   endtask

   task automatic send_random_message();
      logic [BYTE_W-1:0] msg[$];
      int                len;
      int                pick;
      rx_choice_type     choice;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) begin
         repeat (len) msg.push_back(8'h00);
         send_message(msg, RX_GIVEN, '0);
      end else begin
         repeat (len) begin
            pick = $urandom_range(0, 9);
            msg.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : BYTE_W'($urandom()));
         end
         pick   = $urandom_range(0, 5);
         choice = (pick < 2) ? RX_MATCH : (pick == 2) ? RX_ABOVE_DEGREE : RX_RANDOM;
         send_message(msg, choice, '0);
      end
   endtask

   initial begin : stimulus
      logic [BYTE_W-1:0]   msg[$];
      logic [DEGREE_W-1:0] degree_field;
      logic [CRC_W-1:0]    poly_value;
      int                  phase_start;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.data_byte    <= '0;
      req_if.last_byte    <= 1'b0;
      req_if.received_crc <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.wr_index     <= CSR_DEGREE;
      csr_if.wr_data      <= '0;
      degree_now = DEGREE_RESET;
      poly_now   = POLY_RESET;
      burst_left = 0;
      bytes_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: zero and all-ones bytes, a known string, high bits in rx
      msg = '{8'h00};
      send_message(msg, RX_GIVEN, '0);
      msg = '{8'hFF};
      send_message(msg, RX_GIVEN, {CRC_W{1'b1}});
      msg = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
      send_message(msg, RX_MATCH, '0);
      msg = '{8'hFF, 8'h00};
      send_message(msg, RX_ABOVE_DEGREE, '0);
      msg = '{8'h80};
      send_message(msg, RX_MATCH, '0);
      msg = '{8'h00, 8'h00, 8'h00};
      send_message(msg, RX_GIVEN, '0);
      msg = '{8'h01};
      send_message(msg, RX_RANDOM, '0);

      for (int phase = 1; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            1:       begin degree_field = 6'd8;  poly_value = 32'h0000_0007; end
            2:       begin degree_field = 6'd32; poly_value = 32'h04C1_1DB7; end
            3:       begin degree_field = 6'd0;  poly_value = 32'hFFFF_FFFF; end
            4:       begin degree_field = 6'd63; poly_value = 32'h0000_0000; end
            5:       begin degree_field = 6'd7;  poly_value = $urandom(); end
            6:       begin degree_field = 6'd33; poly_value = $urandom(); end
            default: begin
               degree_field = DEGREE_W'($urandom_range(0, 63));
               poly_value   = $urandom();
            end
         endcase
         if (phase % 2) begin
            write_csr(CSR_SPARE_A, $urandom());
            write_csr(CSR_POLY, poly_value);
            write_csr(CSR_DEGREE, {26'($urandom()), degree_field});
            write_csr(CSR_SPARE_B, $urandom());
         end else begin
            write_csr(CSR_DEGREE, {26'($urandom()), degree_field});
            write_csr(CSR_POLY, poly_value);
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < RANDOM_ITEMS / (NUM_PHASES - 1)) begin
            send_random_message();
            if ($urandom_range(0, 39) == 0) wait_idle();
         end
      end

      wait_idle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : response_stall
      stall_style_type style;
      int              segment;
      rsp_if.ready <= 1'b0;
      forever begin
         style   = stall_style_type'($urandom_range(0, 3));
         segment = $urandom_range(20, 200);
         repeat (segment) begin
            @(posedge clock);
            case (style)
               STALL_NONE:  rsp_if.ready <= 1'b1;
               STALL_HALF:  rsp_if.ready <= 1'($urandom_range(0, 1));
               STALL_HEAVY: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_if.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ccrc_pkg.sv
hw/rtl/ccrc_if.sv
hw/rtl/ccrc_csr.sv
hw/rtl/ccrc_byte_step.sv
hw/rtl/configurable_crc_generate_check.sv
dv/ccrc_checker.sv
dv/configurable_crc_generate_check_tb.sv
